/* hdl/assert_macros.svh */
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define ASSERT_PROP(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(name, prop, msg)
`define ASSERT_NEVER(name, cond, msg)

`endif

`endif

/* hdl/rvd_pkg.sv */
package rvd_pkg;

  // major opcodes
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;

  typedef enum logic [2:0] {
    FMT_R   = 3'd0,
    FMT_I   = 3'd1,
    FMT_S   = 3'd2,
    FMT_B   = 3'd3,
    FMT_U   = 3'd4,
    FMT_J   = 3'd5,
    FMT_BAD = 3'd6
  } fmt_e;

  typedef enum logic [5:0] {
    OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
    OP_JALR, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
    OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU, OP_XORI, OP_SRLI, OP_SRAI, OP_ORI, OP_ANDI,
    OP_SB, OP_SH, OP_SW,
    OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
    OP_LUI, OP_AUIPC, OP_JAL, OP_UNDEF
  } op_e;

  typedef enum logic [3:0] {
    KIND_OP, KIND_IMM, KIND_LOAD, KIND_JALR, KIND_STORE,
    KIND_BRANCH, KIND_LUI, KIND_AUIPC, KIND_JAL, KIND_NONE
  } kind_e;

  typedef struct packed {
    logic  zero;
    kind_e kind;
  } cls_t;

  typedef struct packed {
    logic        zero;
    fmt_e        fmt;
    op_e         op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
  } dec_t;

  function automatic op_e r_op(input logic [2:0] f3, input logic hi7);
    op_e o;
    unique case (f3)
      3'd0:    o = hi7 ? OP_SUB : OP_ADD;
      3'd1:    o = OP_SLL;
      3'd2:    o = OP_SLT;
      3'd3:    o = OP_SLTU;
      3'd4:    o = OP_XOR;
      3'd5:    o = hi7 ? OP_SRA : OP_SRL;
      3'd6:    o = OP_OR;
      default: o = OP_AND;
    endcase
    return o;
  endfunction

  function automatic op_e imm_op(input logic [2:0] f3, input logic hi7);
    op_e o;
    unique case (f3)
      3'd0:    o = OP_ADDI;
      3'd1:    o = OP_SLLI;
      3'd2:    o = OP_SLTI;
      3'd3:    o = OP_SLTIU;
      3'd4:    o = OP_XORI;
      3'd5:    o = hi7 ? OP_SRAI : OP_SRLI;
      3'd6:    o = OP_ORI;
      default: o = OP_ANDI;
    endcase
    return o;
  endfunction

  function automatic op_e load_op(input logic [2:0] f3);
    op_e o;
    unique case (f3)
      3'd0:    o = OP_LB;
      3'd1:    o = OP_LH;
      3'd2:    o = OP_LW;
      3'd4:    o = OP_LBU;
      3'd5:    o = OP_LHU;
      default: o = OP_UNDEF;
    endcase
    return o;
  endfunction

  function automatic op_e store_op(input logic [2:0] f3);
    op_e o;
    unique case (f3)
      3'd0:    o = OP_SB;
      3'd1:    o = OP_SH;
      3'd2:    o = OP_SW;
      default: o = OP_UNDEF;
    endcase
    return o;
  endfunction

  function automatic op_e branch_op(input logic [2:0] f3);
    op_e o;
    unique case (f3)
      3'd0:    o = OP_BEQ;
      3'd1:    o = OP_BNE;
      3'd4:    o = OP_BLT;
      3'd5:    o = OP_BGE;
      3'd6:    o = OP_BLTU;
      3'd7:    o = OP_BGEU;
      default: o = OP_UNDEF;
    endcase
    return o;
  endfunction

endpackage

/* hdl/rvd_classify.sv */
module rvd_classify (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [31:0]   word_i,
  input  logic [31:0]   pc_i,
  output logic          vld_o,
  output logic [31:0]   word_o,
  output logic [31:0]   pc_o,
  output rvd_pkg::cls_t cls_o
);
  import rvd_pkg::*;

  logic        vld_q;
  logic [31:0] word_q, pc_q;
  cls_t        cls_d, cls_q;

  always_comb begin
    cls_d.zero = (word_i == 32'd0);
    unique case (word_i[6:0])
      OPC_OP:     cls_d.kind = KIND_OP;
      OPC_OP_IMM: cls_d.kind = KIND_IMM;
      OPC_LOAD:   cls_d.kind = KIND_LOAD;
      OPC_JALR:   cls_d.kind = KIND_JALR;
      OPC_STORE:  cls_d.kind = KIND_STORE;
      OPC_BRANCH: cls_d.kind = KIND_BRANCH;
      OPC_LUI:    cls_d.kind = KIND_LUI;
      OPC_AUIPC:  cls_d.kind = KIND_AUIPC;
      OPC_JAL:    cls_d.kind = KIND_JAL;
      default:    cls_d.kind = KIND_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_i;
    pc_q   <= pc_i;
    cls_q  <= cls_d;
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;
  assign pc_o   = pc_q;
  assign cls_o  = cls_q;

endmodule

/* hdl/rvd_decode.sv */
module rvd_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [31:0]   word_i,
  input  logic [31:0]   pc_i,
  input  rvd_pkg::cls_t cls_i,
  output logic          vld_o,
  output logic [31:0]   pc_o,
  output rvd_pkg::dec_t dec_o
);
  import rvd_pkg::*;

  logic        vld_q;
  logic [31:0] pc_q;
  dec_t        dec_d, dec_q;
  logic [2:0]  f3;
  logic        hi7;

  assign f3  = word_i[14:12];
  assign hi7 = (word_i[31:25] != 7'd0);

  always_comb begin
    dec_d.zero = cls_i.zero;
    dec_d.rd   = word_i[11:7];
    dec_d.rs1  = word_i[19:15];
    dec_d.rs2  = word_i[24:20];
    dec_d.fmt  = FMT_BAD;
    dec_d.op   = OP_UNDEF;
    dec_d.imm  = 32'd0;
    unique case (cls_i.kind)
      KIND_OP: begin
        dec_d.fmt = FMT_R;
        dec_d.op  = r_op(f3, hi7);
      end
      KIND_IMM, KIND_LOAD, KIND_JALR: begin
        dec_d.fmt = FMT_I;
        dec_d.imm = {{20{word_i[31]}}, word_i[31:20]};
        if (cls_i.kind == KIND_JALR) begin
          dec_d.op = OP_JALR;
        end else if (cls_i.kind == KIND_LOAD) begin
          dec_d.op = load_op(f3);
        end else begin
          dec_d.op = imm_op(f3, hi7);
        end
      end
      KIND_STORE: begin
        dec_d.fmt = FMT_S;
        dec_d.op  = store_op(f3);
        dec_d.imm = {{20{word_i[31]}}, word_i[31:25], word_i[11:7]};
      end
      KIND_BRANCH: begin
        dec_d.fmt = FMT_B;
        dec_d.op  = branch_op(f3);
        dec_d.imm = {{20{word_i[31]}}, word_i[7], word_i[30:25], word_i[11:8], 1'b0};
      end
      KIND_LUI, KIND_AUIPC: begin
        dec_d.fmt = FMT_U;
        dec_d.op  = (cls_i.kind == KIND_LUI) ? OP_LUI : OP_AUIPC;
        dec_d.imm = {word_i[31:12], 12'd0};
      end
      KIND_JAL: begin
        dec_d.fmt = FMT_J;
        dec_d.op  = OP_JAL;
        dec_d.imm = {{12{word_i[31]}}, word_i[19:12], word_i[20], word_i[30:21], 1'b0};
      end
      default: begin
        dec_d.fmt = FMT_BAD;
        dec_d.op  = OP_UNDEF;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q  <= pc_i;
    dec_q <= dec_d;
  end

  assign vld_o = vld_q;
  assign pc_o  = pc_q;
  assign dec_o = dec_q;

endmodule

/* hdl/rv32i_instruction_decoder.sv */
// rv32i decoder, three register stages: classify opcode, decode, field select
// done_o is registered through the classify, decode and field-select stages after the edge that takes a word
// throughput: one word every cycle, busy_o stays low
// results cannot be held off; each one shows on the ports for one cycle
// async active-low reset clears the stage valid bits, payload is not reset
`include "assert_macros.svh"

module rv32i_instruction_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [31:0]          instr_word_i,
  input  logic [31:0]          pc_i,
  output logic                 done_o,
  output logic                 valid_res_o,
  output rvd_pkg::fmt_e        format_o,
  output rvd_pkg::op_e         operation_o,
  output logic [4:0]           dest_reg_o,
  output logic [4:0]           src1_reg_o,
  output logic [4:0]           src2_reg_o,
  output logic signed [31:0]   immediate_o,
  output logic [31:0]          pc_out_o
);
  import rvd_pkg::*;

  logic        s1_vld, s2_vld;
  logic [31:0] s1_word, s1_pc, s2_pc;
  cls_t        s1_cls;
  dec_t        s2_dec;

  logic        done_q;
  logic        valid_d, valid_q;
  fmt_e        fmt_d, fmt_q;
  op_e         op_d, op_q;
  logic [4:0]  rd_d, rd_q, rs1_d, rs1_q, rs2_d, rs2_q;
  logic [31:0] imm_d, imm_q, pc_q;
  logic        keep_rd, keep_rs1, keep_rs2;

  assign busy_o = 1'b0;

  rvd_classify u_classify (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i),
    .word_i (instr_word_i),
    .pc_i   (pc_i),
    .vld_o  (s1_vld),
    .word_o (s1_word),
    .pc_o   (s1_pc),
    .cls_o  (s1_cls)
  );

  rvd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s1_vld),
    .word_i (s1_word),
    .pc_i   (s1_pc),
    .cls_i  (s1_cls),
    .vld_o  (s2_vld),
    .pc_o   (s2_pc),
    .dec_o  (s2_dec)
  );

  // register fields survive only where the format carries them
  always_comb begin
    keep_rd  = 1'b0;
    keep_rs1 = 1'b0;
    keep_rs2 = 1'b0;
    unique case (s2_dec.fmt)
      FMT_R: begin
        keep_rd  = 1'b1;
        keep_rs1 = 1'b1;
        keep_rs2 = 1'b1;
      end
      FMT_I: begin
        keep_rd  = 1'b1;
        keep_rs1 = 1'b1;
      end
      FMT_S, FMT_B: begin
        keep_rs1 = 1'b1;
        keep_rs2 = 1'b1;
      end
      FMT_U, FMT_J: begin
        keep_rd = 1'b1;
      end
      default: begin
        keep_rd = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (s2_dec.zero) begin
      valid_d = 1'b0;
      fmt_d   = FMT_R;
      op_d    = OP_ADD;
      rd_d    = 5'd0;
      rs1_d   = 5'd0;
      rs2_d   = 5'd0;
      imm_d   = 32'd0;
    end else begin
      valid_d = 1'b1;
      fmt_d   = s2_dec.fmt;
      op_d    = s2_dec.op;
      rd_d    = keep_rd  ? s2_dec.rd  : 5'd0;
      rs1_d   = keep_rs1 ? s2_dec.rs1 : 5'd0;
      rs2_d   = keep_rs2 ? s2_dec.rs2 : 5'd0;
      imm_d   = s2_dec.imm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    valid_q <= valid_d;
    fmt_q   <= fmt_d;
    op_q    <= op_d;
    rd_q    <= rd_d;
    rs1_q   <= rs1_d;
    rs2_q   <= rs2_d;
    imm_q   <= imm_d;
    pc_q    <= s2_pc;
  end

  assign done_o      = done_q;
  assign valid_res_o = valid_q;
  assign format_o    = fmt_q;
  assign operation_o = op_q;
  assign dest_reg_o  = rd_q;
  assign src1_reg_o  = rs1_q;
  assign src2_reg_o  = rs2_q;
  assign immediate_o = $signed(imm_q);
  assign pc_out_o    = pc_q;

  `ASSERT_PROP(a_latency, (start_i && !busy_o) |-> ##3 done_o, "word lost in pipeline")
  `ASSERT_PROP(a_zero_word, (done_o && !valid_res_o) |-> (format_o == FMT_R && operation_o == OP_ADD && immediate_o == 32'sd0 && dest_reg_o == 5'd0), "zero word not cleared")
  `ASSERT_PROP(a_bad_opcode, (done_o && format_o == FMT_BAD) |-> (operation_o == OP_UNDEF && immediate_o == 32'sd0 && dest_reg_o == 5'd0 && src1_reg_o == 5'd0), "unknown opcode leaks fields")
  `ASSERT_PROP(a_r_imm, (done_o && valid_res_o && format_o == FMT_R) |-> (immediate_o == 32'sd0), "r format with immediate")
  `ASSERT_NEVER(a_u_regs, done_o && format_o == FMT_U && (src1_reg_o != 5'd0 || src2_reg_o != 5'd0), "u format carries source regs")

endmodule
